// ----- rtl/bnc_pkg.sv -----
// Shared types, codes and constants of the nearest color box search.
`timescale 1ns / 1ps
package bnc_pkg;

    // Default table depth
    localparam int NUM_BOXES_DEF = 256;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int ENTRY_W   = 8;
    localparam int CHAN_W    = 8;
    localparam int PIDX_W    = 8;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = 18;
    localparam int BEST_W    = 19;

    // Search starts from this distance; every real sum is below it
    localparam logic [BEST_W-1:0] DIST_START = BEST_W'(256 * 256 * 5);

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_LOW  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_HIGH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_BOXES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ALPHA = 2'd1;

    // One RGBA value, red in the low byte
    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
    } t_rgba;

    // Low corner entry as stored: palette index over the corner
    typedef struct packed {
        logic [PIDX_W-1:0] pidx;
        t_rgba             corner;
    } t_low_entry;

    // Result of the distance unit for one box
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sum;
        logic [PIDX_W-1:0] pidx;
    } t_dist_res;

endpackage

// ----- rtl/bnc_req_if.sv -----
// Request channel: box writes and pixel queries.
`timescale 1ns / 1ps
interface bnc_req_if;
    logic                          valid;
    logic                          ready;
    logic [bnc_pkg::FUNC_W-1:0]    func;
    logic [bnc_pkg::ENTRY_W-1:0]   entry;
    logic [bnc_pkg::CHAN_W-1:0]    chan_r;
    logic [bnc_pkg::CHAN_W-1:0]    chan_g;
    logic [bnc_pkg::CHAN_W-1:0]    chan_b;
    logic [bnc_pkg::CHAN_W-1:0]    chan_a;
    logic [bnc_pkg::PIDX_W-1:0]    color_index;

    modport source (
        output valid, func, entry, chan_r, chan_g, chan_b, chan_a, color_index,
        input  ready
    );
    modport sink (
        input  valid, func, entry, chan_r, chan_g, chan_b, chan_a, color_index,
        output ready
    );
endinterface

// ----- rtl/bnc_rsp_if.sv -----
// Response channel: one beat per query.
`timescale 1ns / 1ps
interface bnc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [bnc_pkg::PIDX_W-1:0]    palette_index;
    logic [bnc_pkg::DIST_W-1:0]    best_distance;

    modport source (
        output valid, found, palette_index, best_distance,
        input  ready
    );
    modport sink (
        input  valid, found, palette_index, best_distance,
        output ready
    );
endinterface

// ----- rtl/bnc_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module bnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bnc_dist.sv -----
// Box distance unit: per-channel gap, registered squares, summed output.
`timescale 1ns / 1ps
module bnc_dist (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_ignore_alpha,
    input  bnc_pkg::t_rgba         i_pix,
    input  bnc_pkg::t_rgba         i_low,
    input  bnc_pkg::t_rgba         i_high,
    input  logic [bnc_pkg::PIDX_W-1:0] i_pidx,
    output bnc_pkg::t_dist_res     o_res
);
    import bnc_pkg::*;

    logic              r_valid;
    logic [PIDX_W-1:0] r_pidx;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b, r_sq_a;
    logic [SQ_W-1:0]   n_sq_r, n_sq_g, n_sq_b, n_sq_a;

    // Gap to the nearer face, zero inside; inverted boxes are not checked
    function automatic logic [CHAN_W-1:0] chan_gap(
        input logic [CHAN_W-1:0] pix,
        input logic [CHAN_W-1:0] lo,
        input logic [CHAN_W-1:0] hi
    );
        logic [CHAN_W-1:0] d;
        d = '0;
        if (pix < lo) begin
            d = lo - pix;
        end else if (hi < pix) begin
            d = pix - hi;
        end
        return d;
    endfunction

    // Four narrow squares in parallel
    always_comb begin
        n_sq_r = chan_gap(i_pix.r, i_low.r, i_high.r) * chan_gap(i_pix.r, i_low.r, i_high.r);
        n_sq_g = chan_gap(i_pix.g, i_low.g, i_high.g) * chan_gap(i_pix.g, i_low.g, i_high.g);
        n_sq_b = chan_gap(i_pix.b, i_low.b, i_high.b) * chan_gap(i_pix.b, i_low.b, i_high.b);
        n_sq_a = i_ignore_alpha ? '0 :
                 chan_gap(i_pix.a, i_low.a, i_high.a) * chan_gap(i_pix.a, i_low.a, i_high.a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_r <= n_sq_r;
        r_sq_g <= n_sq_g;
        r_sq_b <= n_sq_b;
        r_sq_a <= n_sq_a;
        r_pidx <= i_pidx;
    end

    // Sum of the registered squares
    assign o_res.valid = r_valid;
    assign o_res.sum   = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b) + DIST_W'(r_sq_a);
    assign o_res.pidx  = r_pidx;
endmodule

// ----- rtl/nearest_box_color_search.sv -----
// Top level of the nearest color box search: box tables, sequencer, result register.
`timescale 1ns / 1ps
// A write beat (low corner with palette index, or high corner) goes straight
// into its table. A query beat walks entries 0 to boxes_in_use-1 through one
// shared distance unit, one entry per cycle: a table RAM read, a squaring
// stage, a compare stage and a drain check make up the pipeline fill and
// drain, and the done state then parks the result in the output register.
// The request channel is not ready while a query runs; a finished result waits
// in the output register, and the next beat is taken as soon as the search is
// done and the result is parked. Table entries read nothing meaningful until
// written; boxes_in_use above the table depth searches the whole table.
module nearest_box_color_search #(
    parameter int NUM_BOXES = bnc_pkg::NUM_BOXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bnc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bnc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bnc_req_if.sink                          i_req,
    bnc_rsp_if.source                        o_rsp
);
    import bnc_pkg::*;

    localparam int AW    = $clog2(NUM_BOXES);
    localparam int CNT_W = $clog2(NUM_BOXES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_boxes_in_use;
    logic                  r_ignore_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boxes_in_use <= '0;
            r_ignore_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOXES_IN_USE: r_boxes_in_use <= i_cfg_data;
                CFG_IGNORE_ALPHA: r_ignore_alpha <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Request handshake and table writes
    logic       w_acc;
    logic       w_entry_ok;
    logic       w_we_low, w_we_high;
    t_rgba      w_in_rgba;
    t_low_entry w_low_wdata;
    logic [1:0] r_state, n_state;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_entry_ok  = (32'(i_req.entry) < NUM_BOXES);
    assign w_we_low    = w_acc && w_entry_ok && (i_req.func == FUNC_WR_LOW);
    assign w_we_high   = w_acc && w_entry_ok && (i_req.func == FUNC_WR_HIGH);
    assign w_in_rgba   = '{a: i_req.chan_a, b: i_req.chan_b, g: i_req.chan_g, r: i_req.chan_r};
    assign w_low_wdata = '{pidx: i_req.color_index, corner: w_in_rgba};

    logic [AW-1:0] r_addr, n_addr;
    t_low_entry    w_low_rdata;
    t_rgba         w_high_rdata;

    bnc_ram #(.WIDTH($bits(t_low_entry)), .DEPTH(NUM_BOXES)) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_low),
        .i_waddr (AW'(i_req.entry)),
        .i_wdata (w_low_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_low_rdata)
    );

    bnc_ram #(.WIDTH($bits(t_rgba)), .DEPTH(NUM_BOXES)) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_high),
        .i_waddr (AW'(i_req.entry)),
        .i_wdata (w_in_rgba),
        .i_raddr (r_addr),
        .o_rdata (w_high_rdata)
    );

    // Sequencer registers
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  w_count;
    logic              r_rd_vld, n_rd_vld;
    logic              w_issue;
    t_rgba             r_pix, n_pix;
    logic [BEST_W-1:0] r_best, n_best;
    logic [PIDX_W-1:0] r_best_idx, n_best_idx;
    logic              r_found, n_found;
    t_dist_res         w_res;

    // Out-of-range box count saturates to the table depth
    assign w_count = (r_boxes_in_use > NUM_BOXES) ? CNT_W'(NUM_BOXES)
                                                  : CNT_W'(r_boxes_in_use);
    assign w_issue = (r_state == ST_RUN) && (r_left != '0);

    bnc_dist u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_rd_vld),
        .i_ignore_alpha (r_ignore_alpha),
        .i_pix          (r_pix),
        .i_low          (w_low_rdata.corner),
        .i_high         (w_high_rdata),
        .i_pidx         (w_low_rdata.pidx),
        .o_res          (w_res)
    );

    // Output register
    logic              r_out_vld, n_out_vld;
    logic              r_out_found;
    logic [PIDX_W-1:0] r_out_pidx;
    logic [DIST_W-1:0] r_out_dist;
    logic              w_out_load;

    assign w_out_load = (r_state == ST_DONE) && (!r_out_vld || o_rsp.ready);

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_left     = r_left;
        n_rd_vld   = w_issue;
        n_pix      = r_pix;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_req.func == FUNC_QUERY)) begin
                    n_pix      = w_in_rgba;
                    n_addr     = '0;
                    n_left     = w_count;
                    n_best     = DIST_START;
                    n_best_idx = '0;
                    n_found    = (w_count != '0);
                    n_state    = (w_count == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                    n_left = r_left - 1'b1;
                end
                // Strictly smaller wins, so the earlier entry keeps a tie
                if (w_res.valid && (BEST_W'(w_res.sum) < r_best)) begin
                    n_best     = BEST_W'(w_res.sum);
                    n_best_idx = w_res.pidx;
                end
                if ((r_left == '0) && !r_rd_vld && !w_res.valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_out_load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_left    <= n_left;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pix      <= n_pix;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        if (w_out_load) begin
            r_out_found <= r_found;
            r_out_pidx  <= r_best_idx;
            r_out_dist  <= r_found ? r_best[DIST_W-1:0] : '0;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.found         = r_out_found;
    assign o_rsp.palette_index = r_out_pidx;
    assign o_rsp.best_distance = r_out_dist;
endmodule

// ----- rtl/bnc_checker.sv -----
// Port-level checks of the nearest color box search, bound to the top level.
`timescale 1ns / 1ps
module bnc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic [bnc_pkg::FUNC_W-1:0]     i_in_func,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_found,
    input logic [bnc_pkg::PIDX_W-1:0]     i_out_pidx,
    input logic [bnc_pkg::DIST_W-1:0]     i_out_dist
);
    import bnc_pkg::*;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(4 * 255 * 255);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_found) && $stable(i_out_pidx)
            && $stable(i_out_dist))
        else $error("result beat changed while stalled");

    // An empty search reports all zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> (i_out_pidx == '0) && (i_out_dist == '0))
        else $error("empty search returned nonzero fields");

    // Distance never exceeds four full squared gaps
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_dist <= DIST_MAX))
        else $error("best distance out of range");

    // A query keeps the request side busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_func == FUNC_QUERY) |=> !i_in_ready)
        else $error("request ready right after a query");
endmodule

bind nearest_box_color_search bnc_checker u_bnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_func   (i_req.func),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_found (o_rsp.found),
    .i_out_pidx  (o_rsp.palette_index),
    .i_out_dist  (o_rsp.best_distance)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the nearest color box search: box table, queries, config.
`timescale 1ns / 1ps
module tb_top;
    import bnc_pkg::*;

    localparam int NBOX           = NUM_BOXES_DEF;
    localparam int ITEM_TARGET    = 1450;
    localparam int LIMIT_CYCLES   = 3_000_000;
    localparam int TAIL_CYCLES    = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_CAP     = 40;
    localparam int DEPTH_MAX_CODE = (1 << CFG_DATA_W) - 1;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ENTRY_W-1:0] entry;
        t_rgba              pix;
        logic [PIDX_W-1:0]  cidx;
    } req_item_t;

    typedef struct packed {
        logic              found;
        logic [PIDX_W-1:0] pidx;
        logic [DIST_W-1:0] best_sq;
    } match_t;

    // Mirror of the box table and config; predicts one match per query beat
    class box_match_board;
        t_rgba             lo_tab   [NBOX];
        t_rgba             hi_tab   [NBOX];
        logic [PIDX_W-1:0] pidx_tab [NBOX];
        bit                lo_set   [NBOX];
        bit                hi_set   [NBOX];
        int unsigned       boxes_cfg;
        bit                alpha_off;
        match_t            pending[$];
        int                mismatches;
        int                writes_noted;
        int                queries_noted;
        int                spare_noted;
        int                empty_queries;
        int unsigned       deepest;

        function new();
            boxes_cfg     = 0;
            alpha_off     = 1'b0;
            mismatches    = 0;
            writes_noted  = 0;
            queries_noted = 0;
            spare_noted   = 0;
            empty_queries = 0;
            deepest       = 0;
            foreach (lo_set[i]) begin
                lo_set[i]   = 1'b0;
                hi_set[i]   = 1'b0;
                lo_tab[i]   = '0;
                hi_tab[i]   = '0;
                pidx_tab[i] = '0;
            end
        endfunction

        // First entry that still lacks a low or a high corner
        function int unsigned intact_prefix();
            int unsigned n;
            n = 0;
            while (n < NBOX && lo_set[n] && hi_set[n]) n++;
            return n;
        endfunction

        function int unsigned search_depth();
            return (boxes_cfg > NBOX) ? NBOX : boxes_cfg;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BOXES_IN_USE: boxes_cfg = val;
                CFG_IGNORE_ALPHA: alpha_off = val[0];
                default: ;
            endcase
        endfunction

        // Squared gap to the box on one channel; inverted boxes are not special
        static function int unsigned gap_sq(logic [7:0] pix, logic [7:0] lo, logic [7:0] hi);
            int unsigned d;
            d = 0;
            if (pix < lo) d = lo - pix;
            else if (hi < pix) d = pix - hi;
            return d * d;
        endfunction

        function match_t search_nearest(t_rgba pix);
            match_t            m;
            int unsigned       best;
            int unsigned       sum;
            int unsigned       depth;
            logic [PIDX_W-1:0] bidx;
            depth = search_depth();
            best  = 256 * 256 * 5;
            bidx  = '0;
            m     = '0;
            for (int unsigned i = 0; i < depth; i++) begin
                sum = gap_sq(pix.r, lo_tab[i].r, hi_tab[i].r)
                    + gap_sq(pix.g, lo_tab[i].g, hi_tab[i].g)
                    + gap_sq(pix.b, lo_tab[i].b, hi_tab[i].b);
                if (!alpha_off) sum += gap_sq(pix.a, lo_tab[i].a, hi_tab[i].a);
                // strict compare: earliest entry keeps a tie
                if (sum < best) begin
                    best = sum;
                    bidx = pidx_tab[i];
                end
            end
            if (depth != 0) begin
                m.found   = 1'b1;
                m.pidx    = bidx;
                m.best_sq = best[DIST_W-1:0];
            end
            return m;
        endfunction

        function void note_beat(req_item_t it);
            case (it.func)
                FUNC_WR_LOW: begin
                    lo_tab[it.entry]   = it.pix;
                    pidx_tab[it.entry] = it.cidx;
                    lo_set[it.entry]   = 1'b1;
                    writes_noted++;
                end
                FUNC_WR_HIGH: begin
                    hi_tab[it.entry] = it.pix;
                    hi_set[it.entry] = 1'b1;
                    writes_noted++;
                end
                FUNC_QUERY: begin
                    pending.insert(pending.size(), search_nearest(it.pix));
                    queries_noted++;
                    if (search_depth() == 0) empty_queries++;
                    if (search_depth() > deepest) deepest = search_depth();
                end
                default: spare_noted++;
            endcase
        endfunction

        function void check_match(match_t got);
            match_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result with nothing expected: found %0d index %0d dist %0d",
                             $time, got.found, got.pidx, got.best_sq);
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, got.found);
            end
            if (got.pidx !== want.pidx) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: palette_index expected %0d actual %0d",
                             $time, want.pidx, got.pidx);
            end
            if (got.best_sq !== want.best_sq) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: best_distance expected %0d actual %0d",
                             $time, want.best_sq, got.best_sq);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    hold_off_req = 1'b0;
    int                    cycles = 0;

    box_match_board sb = new();

    bnc_req_if req_if ();
    bnc_rsp_if rsp_if ();

    nearest_box_color_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("nearest_box_color_search regression: fail");
            $finish;
        end
    end

    // Biased channel value: faces of the cube and coarse levels show up often
    function automatic logic [7:0] pick_chan();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        if (r < 45) return 8'($urandom_range(1, 3) * 64);
        return 8'($urandom());
    endfunction

    function automatic t_rgba pick_rgba();
        t_rgba c;
        c.r = pick_chan();
        c.g = pick_chan();
        c.b = pick_chan();
        c.a = pick_chan();
        return c;
    endfunction

    function automatic t_rgba rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        t_rgba c;
        c.r = r;
        c.g = g;
        c.b = b;
        c.a = a;
        return c;
    endfunction

    // Mostly short idles, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] stretch(logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(0, 40));
        return (t > 255) ? 8'hFF : 8'(t);
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(0, 8)) - 4;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
    endfunction

    // One request beat, after an optional idle stretch; called at a falling edge
    task automatic offer(input req_item_t it, input int unsigned gap);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.func        <= it.func;
        req_if.entry       <= it.entry;
        req_if.chan_r      <= it.pix.r;
        req_if.chan_g      <= it.pix.g;
        req_if.chan_b      <= it.pix.b;
        req_if.chan_a      <= it.pix.a;
        req_if.color_index <= it.cidx;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_beat(it);
        @(negedge i_clk);
    endtask

    task automatic offer_fixed(input logic [FUNC_W-1:0] f, input logic [7:0] e,
                               input t_rgba pix, input logic [7:0] cidx);
        req_item_t it;
        it.func  = f;
        it.entry = e;
        it.pix   = pix;
        it.cidx  = cidx;
        offer(it, pick_gap());
    endtask

    // Random corner write; high corners mostly sit a little above the low one
    task automatic offer_box_write(input logic [7:0] e, input logic [FUNC_W-1:0] f,
                                   input int unsigned gap);
        req_item_t   it;
        t_rgba       lo;
        int unsigned r;
        it.func  = f;
        it.entry = e;
        it.cidx  = 8'($urandom());
        if (f == FUNC_WR_LOW) begin
            it.pix = pick_rgba();
        end else begin
            lo = sb.lo_tab[e];
            r  = $urandom_range(0, 99);
            if (r < 60) it.pix = rgba(stretch(lo.r), stretch(lo.g), stretch(lo.b), stretch(lo.a));
            else if (r < 85) it.pix = pick_rgba();
            else it.pix = lo;
        end
        offer(it, gap);
    endtask

    // Random query pixel; some land just around a searched box corner
    task automatic offer_query(input int unsigned gap);
        req_item_t   it;
        t_rgba       base;
        int unsigned depth;
        int unsigned r;
        int unsigned j;
        depth    = sb.search_depth();
        r        = $urandom_range(0, 99);
        it.func  = FUNC_QUERY;
        it.entry = 8'($urandom());
        it.cidx  = 8'($urandom());
        if (r < 30 && depth != 0) begin
            j    = $urandom_range(0, depth - 1);
            base = ($urandom_range(0, 1) == 0) ? sb.lo_tab[j] : sb.hi_tab[j];
            it.pix = rgba(nudge(base.r), nudge(base.g), nudge(base.b), nudge(base.a));
        end else if (r < 65) begin
            it.pix = pick_rgba();
        end else begin
            it.pix = $urandom();
        end
        offer(it, gap);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.apply_config(idx, val);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected match, then let trailing writes land
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Response monitor
    always @(posedge i_clk) begin : rsp_mon
        match_t got;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.found   = rsp_if.found;
            got.pidx    = rsp_if.palette_index;
            got.best_sq = rsp_if.best_distance;
            sb.check_match(got);
        end
    end

    // Response ready: random stalls, calm stretches, one long hold-off on request
    initial begin : rsp_drive
        int unsigned stall_left;
        int unsigned hold_left;
        bit          rx_calm;
        bit          hold_done;
        stall_left   = 0;
        hold_left    = 0;
        rx_calm      = 1'b0;
        hold_done    = 1'b0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
            if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
        end
    end

    // Stimulus
    initial begin : stim
        int unsigned p;
        int unsigned lim;
        int unsigned depth;
        int unsigned phase_no;
        int unsigned plen;
        int unsigned qshare;
        int unsigned gap;
        int unsigned r;
        int unsigned r2;
        int unsigned e_top;
        logic [7:0]  e;
        logic [FUNC_W-1:0] f;
        bit          tx_calm;
        req_item_t   spare;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.func        = '0;
        req_if.entry       = '0;
        req_if.chan_r      = '0;
        req_if.chan_g      = '0;
        req_if.chan_b      = '0;
        req_if.chan_a      = '0;
        req_if.color_index = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: query on reset config, i.e. no boxes in use
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'd9, 8'd200, 8'd33, 8'hFF), 8'h00);
        settle();
        write_reg(CFG_BOXES_IN_USE, 9'd0);
        write_reg(CFG_IGNORE_ALPHA, 9'd0);

        // Point boxes at black and white, an inverted box, a duplicate of entry 0
        offer_fixed(FUNC_WR_LOW,  8'd0,   rgba(8'h00, 8'h00, 8'h00, 8'h00), 8'h11);
        offer_fixed(FUNC_WR_HIGH, 8'd0,   rgba(8'h00, 8'h00, 8'h00, 8'h00), 8'h00);
        offer_fixed(FUNC_WR_LOW,  8'd1,   rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF);
        offer_fixed(FUNC_WR_HIGH, 8'd1,   rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF);
        offer_fixed(FUNC_WR_LOW,  8'd2,   rgba(8'd200, 8'd200, 8'd200, 8'd200), 8'h5A);
        offer_fixed(FUNC_WR_HIGH, 8'd2,   rgba(8'd50, 8'd50, 8'd50, 8'd50), 8'hA5);
        offer_fixed(FUNC_WR_LOW,  8'd3,   rgba(8'h00, 8'h00, 8'h00, 8'h00), 8'h33);
        offer_fixed(FUNC_WR_HIGH, 8'd3,   rgba(8'h00, 8'h00, 8'h00, 8'h00), 8'h00);
        offer_fixed(FUNC_WR_LOW,  8'd255, rgba(8'd1, 8'd2, 8'd3, 8'd4), 8'h77);
        offer_fixed(FUNC_WR_HIGH, 8'd255, rgba(8'd5, 8'd6, 8'd7, 8'd8), 8'h00);
        settle();
        write_reg(CFG_BOXES_IN_USE, 9'd4);
        offer_fixed(FUNC_QUERY, 8'hFF, rgba(8'h00, 8'h00, 8'h00, 8'h00), 8'hFF);
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'h00);
        offer_fixed(FUNC_QUERY, 8'h80, rgba(8'd128, 8'd128, 8'd128, 8'd128), 8'h80);
        offer_fixed(FUNC_QUERY, 8'h01, rgba(8'hFF, 8'hFF, 8'hFF, 8'h00), 8'h01);
        settle();
        write_reg(CFG_IGNORE_ALPHA, 9'd1);
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'hFF, 8'hFF, 8'hFF, 8'h00), 8'h00);
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'h00, 8'h00, 8'h00, 8'hFF), 8'h00);
        offer_fixed(FUNC_SPARE, 8'h00, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF);
        settle();
        // Indexes past the register list must not disturb anything
        write_reg(CFG_SPARE_A, 9'(DEPTH_MAX_CODE));
        write_reg(CFG_SPARE_B, 9'd0);
        // Largest possible distance: one point box at black, white pixel, alpha in
        write_reg(CFG_BOXES_IN_USE, 9'd1);
        write_reg(CFG_IGNORE_ALPHA, 9'd0);
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'h00);
        offer_fixed(FUNC_QUERY, 8'h00, rgba(8'h00, 8'hFF, 8'h00, 8'hFF), 8'h00);
        settle();

        // Random phases; queries only ever search entries that were written
        phase_no = 0;
        while (sb.writes_noted + sb.queries_noted < ITEM_TARGET) begin
            phase_no++;
            p   = sb.intact_prefix();
            lim = (p < 12) ? p : 12;
            r   = $urandom_range(0, 99);
            if (r < 6 || p == 0) depth = 0;
            else if (r < 70) depth = $urandom_range(1, lim);
            else if (r < 88) depth = $urandom_range(1, p);
            else if (p == NBOX)
                depth = ($urandom_range(0, 1) == 0) ? NBOX
                                                    : $urandom_range(NBOX + 1, DEPTH_MAX_CODE);
            else depth = p;
            // fixed settings: the intact prefix while the table fills, then saturated, full, empty
            case (phase_no)
                3: depth = p;
                4: if (p == NBOX) depth = DEPTH_MAX_CODE;
                5: if (p == NBOX) depth = NBOX;
                6: depth = 0;
                default: ;
            endcase
            write_reg(CFG_BOXES_IN_USE, 9'(depth));
            write_reg(CFG_IGNORE_ALPHA, 9'($urandom_range(0, 1)));
            tx_calm = ($urandom_range(0, 3) == 0);

            if (phase_no == 3) begin
                // Fill the rest of the table in order, with queries mixed in
                for (int unsigned n = p; n < NBOX; n++) begin
                    offer_box_write(8'(n), FUNC_WR_LOW, tx_calm ? 0 : pick_gap());
                    offer_box_write(8'(n), FUNC_WR_HIGH, tx_calm ? 0 : pick_gap());
                    if ($urandom_range(0, 2) == 0) offer_query(tx_calm ? 0 : pick_gap());
                end
            end else begin
                plen   = $urandom_range(30, 80);
                qshare = 50;
                // query-heavy phase under a long receiver hold-off
                if (phase_no == 2) begin
                    plen         = 120;
                    qshare       = 75;
                    hold_off_req = 1'b1;
                end
                repeat (plen) begin
                    gap = tx_calm ? 0 : pick_gap();
                    r   = $urandom_range(0, 99);
                    if (r < qshare) begin
                        offer_query(gap);
                    end else if (r < 96) begin
                        // up to half the writes extend the written prefix
                        p  = sb.intact_prefix();
                        r2 = $urandom_range(0, 99);
                        if (r2 < 50 && p < NBOX) begin
                            e = 8'(p);
                            f = sb.lo_set[p] ? FUNC_WR_HIGH : FUNC_WR_LOW;
                        end else begin
                            e_top = (p + 4 > NBOX - 1) ? NBOX - 1 : p + 4;
                            if (r2 < 80) e = 8'($urandom_range(0, e_top));
                            else e = 8'($urandom_range(0, NBOX - 1));
                            f = ($urandom_range(0, 1) == 0) ? FUNC_WR_LOW : FUNC_WR_HIGH;
                        end
                        offer_box_write(e, f, gap);
                    end else begin
                        spare.func  = FUNC_SPARE;
                        spare.entry = 8'($urandom());
                        spare.pix   = $urandom();
                        spare.cidx  = 8'($urandom());
                        offer(spare, gap);
                    end
                end
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Covered %0d box writes, %0d pixel queries (%0d with no boxes)",
                 sb.writes_noted, sb.queries_noted, sb.empty_queries);
        $display("and %0d unused beats, depth up to %0d, both alpha modes, %0d-cycle hold-off.",
                 sb.spare_noted, sb.deepest, HOLD_CYCLES);
        if (sb.pending.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("nearest_box_color_search regression: pass");
        end else begin
            $display("nearest_box_color_search regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bnc_pkg.sv
rtl/bnc_req_if.sv
rtl/bnc_rsp_if.sv
rtl/bnc_ram.sv
rtl/bnc_dist.sv
rtl/nearest_box_color_search.sv
rtl/bnc_checker.sv
verif/tb_top.sv
